// ----- design/battery_percent_from_adc_unit_macros.svh -----
// assertion macros for the battery percent block checker
// no dependencies; included by the checker file only
`ifndef BATTERY_PERCENT_FROM_ADC_UNIT_MACROS_SVH
`define BATTERY_PERCENT_FROM_ADC_UNIT_MACROS_SVH

// concurrent assertion on a given clock with an active-low reset
`define BPFA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define BPFA_ASSERT(lbl, prop, msg) \
    `BPFA_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ----- design/bpfa_pkg.sv -----
// shared types, constants and the breakpoint table for the battery percent block
// no dependencies
`default_nettype none

package bpfa_pkg;

    localparam int unsigned SAMPLE_W            = 12;
    localparam int unsigned MV_W                = 13;
    localparam int unsigned PCT_W               = 7;
    localparam int unsigned BP_TABLE_SIZE       = 16;
    localparam int unsigned BP_IDX_W            = 4;
    localparam int unsigned DEF_NUM_BREAKPOINTS = 11;

    // millivolt scaling: mv = (sample * 825) >> 9
    localparam int unsigned SCALE_W  = 10;
    localparam int unsigned PROD_W   = SAMPLE_W + SCALE_W;
    localparam int unsigned MV_SHIFT = 9;
    localparam logic [SCALE_W-1:0] MV_SCALE = 10'd825;

    // serial divider sizing
    localparam int unsigned DIVD_W = 16;
    localparam int unsigned QUO_W  = 4;
    localparam int unsigned STEP_W = 2;
    localparam int unsigned SH_W   = MV_W + QUO_W - 1;

    localparam int unsigned BASE_W = 8;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
    localparam logic [PCT_W-1:0] PCT_MIN = 7'd0;

    localparam logic [MV_W-1:0] BP_FIRST_MV = 13'd3000;
    localparam logic [MV_W-1:0] BP_LAST_MV  = 13'd4150;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [MV_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

    // breakpoint voltages in mV; entries past the eleventh repeat the last one
    function automatic logic [MV_W-1:0] bp_mv(input logic [BP_IDX_W-1:0] idx);
        logic [MV_W-1:0] v;
        case (idx)
            4'd0:    v = BP_FIRST_MV;
            4'd1:    v = 13'd3650;
            4'd2:    v = 13'd3700;
            4'd3:    v = 13'd3740;
            4'd4:    v = 13'd3760;
            4'd5:    v = 13'd3795;
            4'd6:    v = 13'd3840;
            4'd7:    v = 13'd3910;
            4'd8:    v = 13'd3980;
            4'd9:    v = 13'd4070;
            default: v = BP_LAST_MV;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/bpfa_div.sv -----
// restoring serial divider, one quotient bit per cycle
// depends on bpfa_pkg
`default_nettype none

module bpfa_div
    import bpfa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIVD_W-1:0] r_rem;
    logic [MV_W-1:0]   r_dvs;
    logic [QUO_W-1:0]  r_quo;

    logic [SH_W-1:0] dvs_sh;
    logic            trial_ok;

    // quotient is known to fit QUO_W bits, so the divisor starts shifted by QUO_W-1
    assign dvs_sh   = SH_W'(r_dvs) << r_step;
    // zero divisor yields a zero quotient
    assign trial_ok = (r_dvs != '0) && (DIVD_W'(r_rem) >= DIVD_W'(dvs_sh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_step <= STEP_W'(QUO_W - 1);
            r_rem  <= i_req.dividend;
            r_dvs  <= i_req.divisor;
            r_quo  <= '0;
        end else if (r_busy) begin
            if (trial_ok) begin
                r_rem <= r_rem - DIVD_W'(dvs_sh);
            end
            r_quo[r_step] <= trial_ok;
            r_step        <= r_step - 1'b1;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ----- design/battery_percent_from_adc_unit.sv -----
// battery percent block: adc sample to millivolts and state of charge
// Input channel: i_in_valid / o_in_ready carry i_adc_sample (12 bits).
// Output channel: o_out_valid / i_out_ready carry o_battery_mv and
// o_charge_percent, one result transaction per input transaction.
// Flow: the millivolt product is taken at input accept, then the sequencer
// walks the breakpoint table one compare per cycle until the first
// breakpoint above the voltage (or the last one); for a voltage between
// two breakpoints the serial divider forms the interpolation quotient.
// Throughput: one transaction at a time; o_in_ready is high only while the
// sequencer is idle, so a new transaction follows the previous result.
// The result sits in an output register, so a new input is taken while it
// waits; if the receiver still stalls when the next result is ready, the
// sequencer holds it until the register frees.
// Reset: synchronous, active low; clears the sequencer and o_out_valid.
// Depends on bpfa_pkg and bpfa_div.
`default_nettype none

module battery_percent_from_adc_unit
    import bpfa_pkg::*;
#(
    parameter int unsigned NUM_BREAKPOINTS = DEF_NUM_BREAKPOINTS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [SAMPLE_W-1:0] i_adc_sample,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [MV_W-1:0]          o_battery_mv,
    output logic [PCT_W-1:0]         o_charge_percent
);

    localparam int unsigned IDX_W = $clog2(NUM_BREAKPOINTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BREAKPOINTS - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [MV_W-1:0]  r_mv, n_mv;
    logic [PCT_W-1:0] r_pct, n_pct;
    logic             r_out_valid, n_out_valid;
    logic [MV_W-1:0]  r_out_mv, n_out_mv;
    logic [PCT_W-1:0] r_out_pct, n_out_pct;

    logic [PROD_W-1:0] prod;
    logic [MV_W-1:0]   hi, lo, diff, span;
    logic              below;
    logic [BASE_W-1:0] base, quo_ext, pct_raw;
    logic [PCT_W-1:0]  pct_calc;
    logic              in_acc;

    t_div_req div_req;
    t_div_rsp div_rsp;

    bpfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc = i_in_valid && o_in_ready;
    assign prod   = PROD_W'(i_adc_sample) * PROD_W'(MV_SCALE);

    // the shared compare against the current breakpoint
    assign hi    = bp_mv(BP_IDX_W'(r_idx));
    assign lo    = bp_mv(BP_IDX_W'(r_idx - 1'b1));
    assign below = r_mv < hi;
    assign diff  = hi - r_mv;
    assign span  = (hi > lo) ? (hi - lo) : '0;

    // base = idx * 10, then subtract the quotient and clamp
    assign base     = (BASE_W'(r_idx) << 3) + (BASE_W'(r_idx) << 1);
    assign quo_ext  = BASE_W'(div_rsp.quotient);
    assign pct_raw  = (base > quo_ext) ? (base - quo_ext) : '0;
    assign pct_calc = (pct_raw > BASE_W'(PCT_MAX)) ? PCT_MAX : pct_raw[PCT_W-1:0];

    always_comb begin
        n_state          = r_state;
        n_idx            = r_idx;
        n_mv             = r_mv;
        n_pct            = r_pct;
        n_out_valid      = r_out_valid && !i_out_ready;
        n_out_mv         = r_out_mv;
        n_out_pct        = r_out_pct;
        div_req.start    = 1'b0;
        div_req.dividend = (DIVD_W'(diff) << 3) + (DIVD_W'(diff) << 1);
        div_req.divisor  = span;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mv    = prod[MV_SHIFT +: MV_W];
                    n_idx   = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (below) begin
                    if (r_idx == '0) begin
                        n_pct   = PCT_MIN;
                        n_state = S_DONE;
                    end else begin
                        div_req.start = 1'b1;
                        n_state       = S_DIV;
                    end
                end else if (r_idx == LAST_IDX) begin
                    n_pct   = PCT_MAX;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_pct   = pct_calc;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to be free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_mv    = r_mv;
                    n_out_pct   = r_pct;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_mv      <= n_mv;
        r_pct     <= n_pct;
        r_out_mv  <= n_out_mv;
        r_out_pct <= n_out_pct;
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_battery_mv     = r_out_mv;
    assign o_charge_percent = r_out_pct;

endmodule

`default_nettype wire

// ----- design/bpfa_chk.sv -----
// port-level checker for the battery percent block, bound to the top level
// depends on bpfa_pkg and battery_percent_from_adc_unit_macros.svh
`default_nettype none
`include "battery_percent_from_adc_unit_macros.svh"

module bpfa_chk
    import bpfa_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic [SAMPLE_W-1:0] i_adc_sample,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic [MV_W-1:0]     o_battery_mv,
    input wire logic [PCT_W-1:0]    o_charge_percent
);

    // a stalled result keeps its valid and payload
    `BPFA_ASSERT(a_out_hold, i_rst_n && o_out_valid && !i_out_ready |=> o_out_valid, "result dropped while stalled")
    `BPFA_ASSERT(a_out_stable, i_rst_n && o_out_valid && !i_out_ready |=> $stable(o_battery_mv) && $stable(o_charge_percent), "result changed while stalled")
    // the block works on one transaction at a time
    `BPFA_ASSERT(a_busy_after_accept, i_in_valid && o_in_ready |=> !o_in_ready, "ready straight after accept")
    `BPFA_ASSERT(a_pct_range, o_out_valid |-> o_charge_percent <= PCT_MAX, "percent above 100")
    // below the first breakpoint the charge is empty
    `BPFA_ASSERT(a_pct_empty, o_out_valid && (o_battery_mv < BP_FIRST_MV) |-> o_charge_percent == PCT_MIN, "nonzero percent below first breakpoint")

endmodule

bind battery_percent_from_adc_unit bpfa_chk u_bpfa_chk (.*);

`default_nettype wire
